// ===== rtl/core/rcw_pkg.sv =====
// Shared types and constants of the RIFF chunk walker.
`default_nettype none

package rcw_pkg;

    // Chunk ids that open a container.
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_LIST = 32'h4C49_5354;

    // A region with fewer bytes than a header left is skipped.
    localparam logic [31:0] HEADER_BYTES = 32'd8;
    // Bytes of a container form type.
    localparam logic [31:0] FORM_BYTES = 32'd4;

    // Byte counter values on the last byte of a header and of a form type.
    localparam logic [2:0] HEADER_LAST = 3'd7;
    localparam logic [2:0] FORM_LAST = 3'd3;

    // Parse phase, one-hot.
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_FORM   = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    // One open region. Besides its own end and pad flag, each entry carries
    // what is left once every region that ends at the same byte is closed:
    // the pad flag of the outermost of them and the end of the region around
    // them (or a flag saying that this is the file level).
    typedef struct packed {
        logic [31:0] region_end;
        logic        pad;
        logic        bot_pad;
        logic [31:0] below_end;
        logic        below_file;
    } region_entry_t;

    // Stack operations for one transaction.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/riff_chunk_walker_top.sv =====
// RIFF chunk walker: one file byte per transaction in, one record per chunk out.
// Latency: a record is on m_valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle; a stall on the result side holds s_ready low
// only while the result register is full and not taken.
// Several regions that end on the same byte are all closed by a single pop.
// Reset is synchronous, active low; position, phase, stack and file length clear.
`default_nettype none

module riff_chunk_walker_top #(
    parameter int MAX_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // Byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_restart,
    // Chunk records
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_chunk_id,
    output logic [31:0]      m_chunk_size,
    output logic [31:0]      m_data_offset,
    output logic [31:0]      m_form_type,
    output logic [3:0]       m_nest_level,
    output logic             m_is_container,
    output logic             m_too_deep
);

    localparam int DEPTHW = $clog2(MAX_DEPTH + 1);

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Parser state
    logic [31:0]            file_length_reg;
    logic [31:0]            pos_reg,   pos_next;
    rcw_pkg::phase_t        phase_reg, phase_next;
    logic [2:0]             cnt_reg,   cnt_next;
    logic [63:0]            hdr_reg,   hdr_next;
    logic [31:0]            form_reg,  form_next;
    logic [31:0]            skip_reg,  skip_next;
    logic [31:0]            pend_end_reg, pend_end_next;
    logic                   pend_pad_reg, pend_pad_next;

    // Result register
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_chunk_id_reg;
    logic [31:0]            m_chunk_size_reg;
    logic [31:0]            m_data_offset_reg;
    logic [31:0]            m_form_type_reg;
    logic [3:0]             m_nest_level_reg;
    logic                   m_is_container_reg;
    logic                   m_too_deep_reg;

    // Stack interface
    rcw_pkg::stack_ctrl_t   stk_ctrl;
    rcw_pkg::region_entry_t push_entry;
    logic [DEPTHW-1:0]      push_below_depth;
    logic [DEPTHW-1:0]      stk_depth;
    rcw_pkg::region_entry_t top;
    logic [DEPTHW-1:0]      top_below_depth;

    // Working values
    logic                   accept;
    logic [31:0]            e_pos;
    rcw_pkg::phase_t        e_phase;
    logic [2:0]             e_cnt;
    logic [DEPTHW-1:0]      e_depth;
    logic [31:0]            r_cur;
    logic [31:0]            r_below;
    logic                   skip_hold;
    logic                   at_hdr_start;
    logic [63:0]            hdr_in;
    logic [31:0]            form_in;
    logic [31:0]            id_w;
    logic [31:0]            size_w;
    logic [31:0]            off_w;
    logic [32:0]            leaf_end_w;
    logic [31:0]            leaf_tgt;
    logic [32:0]            cont_end_w;
    logic [31:0]            cont_tgt;
    logic [32:0]            deep_end_w;
    logic [31:0]            deep_tgt;
    logic                   is_cont_w;
    logic                   small_w;
    logic                   same_end;
    logic [3:0]             level_w;
    logic                   emit;
    logic [31:0]            res_id;
    logic [31:0]            res_size;
    logic [31:0]            res_off;
    logic [31:0]            res_form;
    logic                   res_cont;
    logic                   res_deep;

    rcw_region_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTHW    (DEPTHW)
    ) u_stack (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (stk_ctrl),
        .push_entry       (push_entry),
        .push_below_depth (push_below_depth),
        .depth            (stk_depth),
        .top_entry        (top),
        .top_below_depth  (top_below_depth)
    );

    // Handshake: a byte is taken whenever the result register can take a record.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // A restart clears position, phase and stack before the byte is used.
    assign e_pos   = s_restart ? '0 : pos_reg;
    assign e_phase = s_restart ? rcw_pkg::PH_HEADER : phase_reg;
    assign e_cnt   = s_restart ? '0 : cnt_reg;
    assign e_depth = s_restart ? '0 : stk_depth;

    // Current region end, and the region left after closing the top run.
    assign r_cur   = (e_depth != '0) ? top.region_end : file_length_reg;
    assign r_below = top.below_file ? file_length_reg : top.below_end;

    assign skip_hold    = (e_phase == rcw_pkg::PH_SKIP) && (e_pos < skip_reg);
    assign at_hdr_start = ((e_phase == rcw_pkg::PH_SKIP) && !skip_hold) ||
                          ((e_phase == rcw_pkg::PH_HEADER) && (e_cnt == '0));

    // Header decode on its last byte.
    assign hdr_in    = {hdr_reg[55:0], s_data_byte};
    assign form_in   = {form_reg[23:0], s_data_byte};
    assign id_w      = hdr_in[63:32];
    assign size_w    = swap32(hdr_in[31:0]);
    assign off_w     = e_pos + 32'd1;
    assign is_cont_w = (id_w == rcw_pkg::ID_RIFF) || (id_w == rcw_pkg::ID_LIST);

    assign leaf_end_w = {1'b0, off_w} + {1'b0, size_w} + {32'd0, size_w[0]};
    assign leaf_tgt   = (leaf_end_w < {1'b0, r_cur}) ? leaf_end_w[31:0] : r_cur;
    assign cont_end_w = {1'b0, off_w} + {1'b0, size_w};
    assign cont_tgt   = (cont_end_w < {1'b0, r_cur}) ? cont_end_w[31:0] : r_cur;
    assign small_w    = (size_w < rcw_pkg::FORM_BYTES) ||
                        ((r_cur - off_w) < rcw_pkg::FORM_BYTES);

    // Skip target of a container nested too deep: its end plus pad, clamped.
    assign deep_end_w = {1'b0, pend_end_reg} + {32'd0, pend_pad_reg};
    assign deep_tgt   = (deep_end_w < {1'b0, r_cur}) ? deep_end_w[31:0] : r_cur;

    // A new region that ends with the current top joins the top's run.
    assign same_end = (e_depth != '0) && (pend_end_reg == top.region_end);
    assign level_w  = 4'(e_depth);

    // Stack entry for a container that opens.
    always_comb begin
        push_entry.region_end = pend_end_reg;
        push_entry.pad        = pend_pad_reg;
        if (same_end) begin
            push_entry.bot_pad    = top.bot_pad;
            push_entry.below_end  = top.below_end;
            push_entry.below_file = top.below_file;
            push_below_depth      = top_below_depth;
        end else begin
            push_entry.bot_pad    = pend_pad_reg;
            push_entry.below_end  = top.region_end;
            push_entry.below_file = (e_depth == '0);
            push_below_depth      = e_depth;
        end
    end

    // Per-byte parse step.
    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        hdr_next      = hdr_reg;
        form_next     = form_reg;
        skip_next     = skip_reg;
        pend_end_next = pend_end_reg;
        pend_pad_next = pend_pad_reg;
        stk_ctrl      = '0;
        emit          = 1'b0;
        res_id        = hdr_reg[63:32];
        res_size      = swap32(hdr_reg[31:0]);
        res_off       = e_pos - 32'd3;
        res_form      = form_in;
        res_cont      = 1'b1;
        res_deep      = 1'b0;

        if (accept) begin
            pos_next       = e_pos + 32'd1;
            phase_next     = e_phase;
            cnt_next       = e_cnt;
            stk_ctrl.clear = s_restart;

            if (skip_hold) begin
                // Byte lies inside a skipped span.
                phase_next = rcw_pkg::PH_SKIP;
            end else if (at_hdr_start) begin
                phase_next = rcw_pkg::PH_HEADER;
                cnt_next   = '0;
                if (e_pos >= r_cur) begin
                    if (e_depth != '0) begin
                        // Close every region that ends here in one step.
                        stk_ctrl.pop = 1'b1;
                        if (top.bot_pad && (r_below > e_pos)) begin
                            phase_next = rcw_pkg::PH_SKIP;
                            skip_next  = e_pos + 32'd1;
                        end else if (top.below_file && (e_pos >= file_length_reg)) begin
                            // Past the end of the file: byte is ignored.
                            phase_next = rcw_pkg::PH_HEADER;
                        end else if ((r_below - e_pos) < rcw_pkg::HEADER_BYTES) begin
                            phase_next = rcw_pkg::PH_SKIP;
                            skip_next  = r_below;
                        end else begin
                            hdr_next = hdr_in;
                            cnt_next = 3'd1;
                        end
                    end
                end else if ((r_cur - e_pos) < rcw_pkg::HEADER_BYTES) begin
                    // Too little room for a header: skip to the region end.
                    phase_next = rcw_pkg::PH_SKIP;
                    skip_next  = r_cur;
                end else begin
                    hdr_next = hdr_in;
                    cnt_next = 3'd1;
                end
            end else if (e_phase == rcw_pkg::PH_HEADER) begin
                hdr_next = hdr_in;
                cnt_next = e_cnt + 3'd1;
                if (e_cnt == rcw_pkg::HEADER_LAST) begin
                    cnt_next = '0;
                    res_id   = id_w;
                    res_size = size_w;
                    res_off  = off_w;
                    res_form = '0;
                    res_cont = is_cont_w;
                    if (!is_cont_w || small_w) begin
                        // Leaf or empty container: record now, skip its body.
                        emit       = 1'b1;
                        phase_next = rcw_pkg::PH_SKIP;
                        skip_next  = leaf_tgt;
                    end else begin
                        phase_next    = rcw_pkg::PH_FORM;
                        form_next     = '0;
                        pend_end_next = cont_tgt;
                        pend_pad_next = size_w[0];
                    end
                end
            end else if (e_phase == rcw_pkg::PH_FORM) begin
                form_next = form_in;
                cnt_next  = e_cnt + 3'd1;
                if (e_cnt == rcw_pkg::FORM_LAST) begin
                    cnt_next = '0;
                    emit     = 1'b1;
                    if (e_depth >= DEPTHW'(MAX_DEPTH)) begin
                        // No room on the stack: flag it and skip the contents.
                        res_deep   = 1'b1;
                        phase_next = rcw_pkg::PH_SKIP;
                        skip_next  = deep_tgt;
                    end else begin
                        stk_ctrl.push = 1'b1;
                        phase_next    = rcw_pkg::PH_HEADER;
                    end
                end
            end
        end
    end

    // Result register handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
            pos_reg         <= '0;
            phase_reg       <= rcw_pkg::PH_HEADER;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                file_length_reg <= cfg_wr_data;
            end
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Shift registers and targets.
    always_ff @(posedge aclk) begin
        hdr_reg      <= hdr_next;
        form_reg     <= form_next;
        skip_reg     <= skip_next;
        pend_end_reg <= pend_end_next;
        pend_pad_reg <= pend_pad_next;
    end

    // Record payload, loaded with each new record.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_chunk_id_reg     <= res_id;
            m_chunk_size_reg   <= res_size;
            m_data_offset_reg  <= res_off;
            m_form_type_reg    <= res_form;
            m_nest_level_reg   <= level_w;
            m_is_container_reg <= res_cont;
            m_too_deep_reg     <= res_deep;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_chunk_id     = m_chunk_id_reg;
    assign m_chunk_size   = m_chunk_size_reg;
    assign m_data_offset  = m_data_offset_reg;
    assign m_form_type    = m_form_type_reg;
    assign m_nest_level   = m_nest_level_reg;
    assign m_is_container = m_is_container_reg;
    assign m_too_deep     = m_too_deep_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rcw_region_stack.sv =====
// Bounded stack of open regions with a one-step pop of a whole run of equal ends.
`default_nettype none

module rcw_region_stack #(
    parameter int MAX_DEPTH = 8,
    parameter int DEPTHW    = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rcw_pkg::stack_ctrl_t  ctrl,
    input  wire rcw_pkg::region_entry_t push_entry,
    input  wire logic [DEPTHW-1:0]     push_below_depth,
    output logic [DEPTHW-1:0]          depth,
    output rcw_pkg::region_entry_t     top_entry,
    output logic [DEPTHW-1:0]          top_below_depth
);

    localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    rcw_pkg::region_entry_t entry_reg [MAX_DEPTH];
    logic [DEPTHW-1:0]      below_depth_reg [MAX_DEPTH];
    logic [DEPTHW-1:0]      depth_reg;
    logic [DEPTHW-1:0]      depth_next;
    logic [DEPTHW-1:0]      top_pos;
    logic [IDXW-1:0]        rd_idx;
    logic [IDXW-1:0]        wr_idx;

    // The top entry sits one below the fill level.
    assign top_pos = depth_reg - DEPTHW'(1);
    assign rd_idx  = top_pos[IDXW-1:0];
    assign wr_idx  = depth_reg[IDXW-1:0];

    assign depth           = depth_reg;
    assign top_entry       = entry_reg[rd_idx];
    assign top_below_depth = below_depth_reg[rd_idx];

    // Fill level: a pop drops straight to the depth stored with the top entry.
    always_comb begin
        depth_next = depth_reg;
        if (ctrl.clear) begin
            depth_next = '0;
        end else if (ctrl.pop) begin
            depth_next = top_below_depth;
        end else if (ctrl.push) begin
            depth_next = depth_reg + DEPTHW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Entry storage, written at the fill level on a push.
    always_ff @(posedge aclk) begin
        if (ctrl.push && !ctrl.clear) begin
            entry_reg[wr_idx]       <= push_entry;
            below_depth_reg[wr_idx] <= push_below_depth;
        end
    end

endmodule

`default_nettype wire

// ===== dv/riff_chunk_walker_top_tb.sv =====
// Self-checking testbench for the RIFF chunk walker: byte stream in, chunk records checked.
`timescale 1ns / 100ps

module riff_chunk_walker_top_tb;

    localparam int MAX_DEPTH = 8;

    // One chunk record as the block reports it.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] form;
        logic [3:0]  level;
        logic        box;
        logic        deep;
    } chunk_rec_t;

    // One row of the directed file: a byte, its restart flag and, where it is
    // obvious, the record that the byte completes.
    typedef struct packed {
        logic       rs;
        logic [7:0] b;
        logic       typed;
        chunk_rec_t rec;
    } dir_row_t;

    localparam chunk_rec_t REC_WAVE =
        '{rcw_pkg::ID_RIFF, 32'd12, 32'd8, "WAVE", 4'd0, 1'b1, 1'b0};
    localparam chunk_rec_t REC_DATA =
        '{"data", 32'hFFFF_FFFF, 32'd20, 32'd0, 4'd1, 1'b0, 1'b0};
    localparam chunk_rec_t REC_SMALL_LIST =
        '{rcw_pkg::ID_LIST, 32'd3, 32'd8, 32'd0, 4'd0, 1'b1, 1'b0};

    // File length 20: a RIFF/WAVE region holding a data chunk whose size runs
    // past the region, a byte past the end of the file, then a new file that
    // opens with a LIST too small to hold a form type.
    localparam dir_row_t DIR_ROWS [29] = '{
        '{1'b1, 8'h52, 1'b0, '0}, '{1'b0, 8'h49, 1'b0, '0},
        '{1'b0, 8'h46, 1'b0, '0}, '{1'b0, 8'h46, 1'b0, '0},
        '{1'b0, 8'h0C, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h57, 1'b0, '0}, '{1'b0, 8'h41, 1'b0, '0},
        '{1'b0, 8'h56, 1'b0, '0}, '{1'b0, 8'h45, 1'b1, REC_WAVE},
        '{1'b0, 8'h64, 1'b0, '0}, '{1'b0, 8'h61, 1'b0, '0},
        '{1'b0, 8'h74, 1'b0, '0}, '{1'b0, 8'h61, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0}, '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 8'hFF, 1'b0, '0}, '{1'b0, 8'hFF, 1'b1, REC_DATA},
        '{1'b0, 8'hFF, 1'b0, '0},
        '{1'b1, 8'h4C, 1'b0, '0}, '{1'b0, 8'h49, 1'b0, '0},
        '{1'b0, 8'h53, 1'b0, '0}, '{1'b0, 8'h54, 1'b0, '0},
        '{1'b0, 8'h03, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b1, REC_SMALL_LIST}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_restart;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_chunk_id;
    logic [31:0] m_chunk_size;
    logic [31:0] m_data_offset;
    logic [31:0] m_form_type;
    logic [3:0]  m_nest_level;
    logic        m_is_container;
    logic        m_too_deep;

    riff_chunk_walker_top #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chunk_id    (m_chunk_id),
        .m_chunk_size  (m_chunk_size),
        .m_data_offset (m_data_offset),
        .m_form_type   (m_form_type),
        .m_nest_level  (m_nest_level),
        .m_is_container(m_is_container),
        .m_too_deep    (m_too_deep)
    );

    // Records still owed by the block, oldest first.
    chunk_rec_t pending_records [$];
    // Bytes of the file under construction.
    logic [7:0] file_q [$];

    // Queue a record at the tail of the owed list.
    function automatic void owe_record(input chunk_rec_t rec);
        pending_records.insert(pending_records.size(), rec);
    endfunction

    // Add one byte at the end of the file under construction.
    function automatic void append_byte(input logic [7:0] v);
        file_q.insert(file_q.size(), v);
    endfunction

    int fail_count;
    int records_checked;
    int deep_records;
    int items_sent;
    int length_settings;
    int idle_odds;
    int ready_hold;

    // Walker state as the testbench tracks it.
    logic [31:0]     walk_file_len;
    logic [31:0]     walk_pos;
    rcw_pkg::phase_t walk_phase;
    int unsigned     walk_cnt;
    logic [63:0]     walk_hdr_sr;
    logic [31:0]     walk_form_sr;
    logic [31:0]     walk_skip_end;
    logic [32:0]     walk_pend;
    logic [32:0]     walk_stack [MAX_DEPTH];
    int unsigned     walk_depth;

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] min_u64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // End of the innermost open region, or the file end at top level.
    function automatic logic [63:0] walk_region_end();
        if (walk_depth > 0 && walk_depth <= MAX_DEPTH) begin
            return {32'd0, walk_stack[walk_depth - 1][31:0]};
        end
        return {32'd0, walk_file_len};
    endfunction

    function automatic void walk_skip(input logic [63:0] target);
        walk_phase = rcw_pkg::PH_SKIP;
        walk_cnt = 0;
        walk_skip_end = target[31:0];
    endfunction

    function automatic void walk_clear();
        walk_pos = '0;
        walk_phase = rcw_pkg::PH_HEADER;
        walk_cnt = 0;
        walk_hdr_sr = '0;
        walk_form_sr = '0;
        walk_skip_end = '0;
        walk_pend = '0;
        walk_depth = 0;
    endfunction

    // Id and little-endian size as they sit in the header shift register.
    function automatic chunk_rec_t walk_header_rec();
        chunk_rec_t rec;
        rec = '0;
        rec.id = walk_hdr_sr[63:32];
        rec.size = {walk_hdr_sr[7:0], walk_hdr_sr[15:8], walk_hdr_sr[23:16], walk_hdr_sr[31:24]};
        rec.level = 4'(walk_depth);
        return rec;
    endfunction

    // Close finished regions and leave skips before a byte is taken.
    // Returns 0 when the byte lies past the end of the file.
    function automatic bit walk_settle();
        logic [63:0] p;
        logic [63:0] r;
        logic [32:0] e;
        logic [63:0] resume;
        for (int n = 0; n <= MAX_DEPTH + 2; n++) begin
            p = {32'd0, walk_pos};
            if (walk_phase == rcw_pkg::PH_SKIP) begin
                if (p < {32'd0, walk_skip_end}) return 1'b1;
                walk_phase = rcw_pkg::PH_HEADER;
                walk_cnt = 0;
            end
            if (walk_phase != rcw_pkg::PH_HEADER || walk_cnt != 0) return 1'b1;
            r = walk_region_end();
            if (p < r) begin
                // Too few bytes left for a header: skip to the region end.
                if (r - p < {32'd0, rcw_pkg::HEADER_BYTES}) walk_skip(r);
                return 1'b1;
            end
            if (walk_depth == 0 || walk_depth > MAX_DEPTH) return 1'b0;
            e = walk_stack[walk_depth - 1];
            walk_depth--;
            resume = min_u64({32'd0, e[31:0]} + {63'd0, e[32]}, walk_region_end());
            if (resume > p) walk_skip(resume);
        end
        return 1'b0;
    endfunction

    // Header complete: leaf and empty containers report now, others read a form.
    function automatic bit walk_end_header(output chunk_rec_t rec);
        logic [63:0] off;
        logic [63:0] r;
        logic [63:0] size;
        logic [63:0] pad;
        off = {32'd0, walk_pos} + 64'd1;
        r = walk_region_end();
        rec = walk_header_rec();
        rec.offset = off[31:0];
        size = {32'd0, rec.size};
        pad = {63'd0, size[0]};
        walk_cnt = 0;
        if (rec.id != rcw_pkg::ID_RIFF && rec.id != rcw_pkg::ID_LIST) begin
            walk_skip(min_u64(off + size + pad, r));
            return 1'b1;
        end
        rec.box = 1'b1;
        if (size < {32'd0, rcw_pkg::FORM_BYTES} || r - off < {32'd0, rcw_pkg::FORM_BYTES}) begin
            walk_skip(min_u64(off + size + pad, r));
            return 1'b1;
        end
        r = min_u64(off + size, r);
        walk_pend = {pad[0], r[31:0]};
        walk_phase = rcw_pkg::PH_FORM;
        walk_form_sr = '0;
        return 1'b0;
    endfunction

    // Form type complete: open the region, or skip it when the stack is full.
    function automatic bit walk_end_form(output chunk_rec_t rec);
        logic [63:0] target;
        rec = walk_header_rec();
        rec.offset = walk_pos - (rcw_pkg::FORM_BYTES - 32'd1);
        rec.form = walk_form_sr;
        rec.box = 1'b1;
        walk_cnt = 0;
        if (walk_depth >= MAX_DEPTH) begin
            target = {32'd0, walk_pend[31:0]} + {63'd0, walk_pend[32]};
            walk_skip(min_u64(target, walk_region_end()));
            rec.deep = 1'b1;
            return 1'b1;
        end
        walk_stack[walk_depth] = walk_pend;
        walk_depth++;
        walk_phase = rcw_pkg::PH_HEADER;
        return 1'b1;
    endfunction

    // Advance the walker by one accepted byte; returns 1 with the record it completes.
    function automatic bit walk_byte(input logic [7:0] b, input logic rs, output chunk_rec_t rec);
        bit made;
        made = 1'b0;
        rec = '0;
        if (rs) walk_clear();
        if (walk_settle()) begin
            if (walk_phase == rcw_pkg::PH_HEADER) begin
                walk_hdr_sr = {walk_hdr_sr[55:0], b};
                walk_cnt++;
                if (walk_cnt >= rcw_pkg::HEADER_BYTES) made = walk_end_header(rec);
            end else if (walk_phase == rcw_pkg::PH_FORM) begin
                walk_form_sr = {walk_form_sr[23:0], b};
                walk_cnt++;
                if (walk_cnt >= rcw_pkg::FORM_BYTES) made = walk_end_form(rec);
            end
        end
        walk_pos++;
        return made;
    endfunction

    // Present one byte, hold it until accepted, then record what it owes.
    task automatic send_byte(input logic [7:0] b, input logic rs,
                             input bit typed = 1'b0, input chunk_rec_t typed_rec = '0);
        chunk_rec_t rec;
        bit made;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_restart <= rs;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        made = walk_byte(b, rs, rec);
        if (typed) begin
            owe_record(typed_rec);
        end else if (made) begin
            owe_record(rec);
        end
    endtask

    // Wait for every owed record, then let the pipeline settle.
    task automatic wait_idle();
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_file_length(input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        walk_file_len = v;
        length_settings++;
    endtask

    // Write a 32-bit little-endian size into the file at a given index.
    function automatic void put_le(input int at, input logic [31:0] v);
        for (int i = 0; i < 4; i++) file_q[at + i] = v[8 * i +: 8];
    endfunction

    // Append one chunk. A container holds random children; a chain nests
    // containers past the stack depth. Sizes are sometimes wrong on purpose.
    task automatic add_chunk(input int level, input bit box, input bit chain);
        int at;
        int body;
        int len;
        logic [31:0] id;
        logic [31:0] size_field;
        if (box || chain || (level < 4 && $urandom_range(0, 99) < 30)) begin
            id = $urandom_range(0, 1) ? rcw_pkg::ID_RIFF : rcw_pkg::ID_LIST;
        end else begin
            id = $urandom();
            if ($urandom_range(0, 3) == 0) id = "data";
        end
        for (int i = 3; i >= 0; i--) append_byte(id[8 * i +: 8]);
        at = file_q.size();
        repeat (4) append_byte(8'h00);
        body = file_q.size();
        if (id == rcw_pkg::ID_RIFF || id == rcw_pkg::ID_LIST) begin
            repeat (4) append_byte(8'($urandom()));
            if (chain && level <= MAX_DEPTH) add_chunk(level + 1, 1'b1, 1'b1);
            repeat (chain ? $urandom_range(0, 1) : $urandom_range(0, 3)) begin
                add_chunk(level + 1, 1'b0, 1'b0);
            end
            // Leftover bytes too few for a header.
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 7)) append_byte(8'($urandom()));
            end
        end else begin
            repeat ($urandom_range(0, 11)) append_byte(8'($urandom()));
        end
        len = file_q.size() - body;
        size_field = len;
        case ($urandom_range(0, 19))
            0: size_field = $urandom_range(0, 3);
            1: size_field = len + $urandom_range(1, 9);
            2: size_field = $urandom();
            3: size_field = 32'hFFFF_FFFF;
            default: ;
        endcase
        put_le(at, size_field);
        if (len[0] && $urandom_range(0, 4) != 0) append_byte(8'($urandom()));
    endtask

    // One file under one length setting, with noise and truncation at random.
    task automatic run_file();
        logic [31:0] len_cfg;
        int total;
        int cut;
        file_q.delete();
        add_chunk(0, 1'b1, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 2)) add_chunk(0, 1'b0, 1'b0);
        total = file_q.size();
        case ($urandom_range(0, 19))
            0: len_cfg = 32'd0;
            1, 2, 3, 4, 5: len_cfg = 32'hFFFF_FFFF;
            6, 7, 8: len_cfg = total - $urandom_range(1, total / 2);
            9, 10: len_cfg = total + $urandom_range(1, 24);
            default: len_cfg = total;
        endcase
        wait_idle();
        set_file_length(len_cfg);
        case ($urandom_range(0, 3))
            0: idle_odds = 0;
            1: idle_odds = 4;
            2: idle_odds = 12;
            default: idle_odds = 30;
        endcase
        // The last part of the run goes without idling.
        if (items_sent > 550) idle_odds = 0;
        // Noise ahead of the file, with restarts at random.
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
        end
        // A broken file stops at a random point.
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
        for (int i = 0; i < cut; i++) send_byte(file_q[i], i == 0);
        // Noise after the file.
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom()), 1'b0);
        end
        s_valid <= 1'b0;
    endtask

    // Result side: ready drops in random bursts.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            ready_hold <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every record transaction with the oldest owed record.
    always @(posedge aclk) begin : rec_check
        chunk_rec_t seen;
        chunk_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_chunk_id, m_chunk_size, m_data_offset, m_form_type,
                     m_nest_level, m_is_container, m_too_deep};
            if (pending_records.size() == 0) begin
                if (fail_count < 10) begin
                    $display("%0t: record with none owed: id=%h size=%h off=%h form=%h",
                             $time, seen.id, seen.size, seen.offset, seen.form);
                end
                fail_count++;
            end else begin
                want = pending_records.pop_front();
                records_checked++;
                if (want.deep) deep_records++;
                if (seen !== want) begin
                    if (fail_count < 10) begin
                        $display("%0t: record mismatch", $time);
                        $display("  expected id=%h size=%h off=%h form=%h level=%0d box=%0b deep=%0b",
                                 want.id, want.size, want.offset, want.form,
                                 want.level, want.box, want.deep);
                        $display("  actual   id=%h size=%h off=%h form=%h level=%0d box=%0b deep=%0b",
                                 seen.id, seen.size, seen.offset, seen.form,
                                 seen.level, seen.box, seen.deep);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data_byte = '0;
        s_restart = 1'b0;
        m_ready = 1'b0;
        ready_hold = 0;
        idle_odds = 0;
        fail_count = 0;
        records_checked = 0;
        deep_records = 0;
        items_sent = 0;
        length_settings = 0;
        walk_clear();
        walk_file_len = '0;
        for (int i = 0; i < MAX_DEPTH; i++) walk_stack[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed file.
        set_file_length(32'd20);
        idle_odds = 6;
        foreach (DIR_ROWS[i]) begin
            send_byte(DIR_ROWS[i].b, DIR_ROWS[i].rs, DIR_ROWS[i].typed, DIR_ROWS[i].rec);
        end
        s_valid <= 1'b0;

        // Random files, then the largest length once more.
        while (items_sent < 650) run_file();
        wait_idle();
        set_file_length(32'hFFFF_FFFF);
        idle_odds = 0;
        file_q.delete();
        add_chunk(0, 1'b1, 1'b1);
        foreach (file_q[i]) send_byte(file_q[i], i == 0);
        s_valid <= 1'b0;

        wait_idle();
        fail_count += pending_records.size();
        $display("Sent %0d file bytes under %0d file length settings.",
                 items_sent, length_settings);
        $display("Checked %0d chunk records, %0d of them containers past the stack depth.",
                 records_checked, deep_records);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
